// File: src/heart_rate_spo2_sample_qualifier_macros.svh
// Assertion macros used by the checker hsq_checker.
`ifndef HEART_RATE_SPO2_SAMPLE_QUALIFIER_MACROS_SVH
`define HEART_RATE_SPO2_SAMPLE_QUALIFIER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HSQ_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hsq: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define HSQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hsq: next-cycle check failed");

`endif

// File: src/hsq_pkg.sv
`default_nettype none

package hsq_pkg;

    // Window geometry default
    localparam int DEFAULT_WINDOW_DEPTH = 8;

    // Stream widths (bits; data widths padded to bytes)
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 24;
    localparam int M_USER_W = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 8;

    // Field widths
    localparam int RATE_W = 12;
    localparam int OXY_IN_W = 8;
    localparam int OXY_W = 7;
    localparam int SHOWN_RATE_W = 8;
    localparam int CNT_W = 3;
    localparam int FILL_CFG_W = 4;
    localparam int PROD_W = 21;

    // Register reset values
    localparam logic [7:0] HR_LOW_RST = 8'd40;
    localparam logic [7:0] HR_HIGH_RST = 8'd180;
    localparam logic [6:0] OXY_LOW_RST = 7'd70;
    localparam logic [6:0] OXY_HIGH_RST = 7'd99;
    localparam logic [6:0] OXY_JUMP_RST = 7'd10;
    localparam logic [2:0] MISS_LIMIT_RST = 3'd6;
    localparam logic [2:0] REJECT_LIMIT_RST = 3'd5;
    localparam logic [3:0] MIN_FILL_RST = 4'd3;

    // Halved-rate correction: below 90 bpm, within 20 bpm (Q8.4)
    localparam logic [RATE_W-1:0] DOUBLE_BELOW_Q4 = 12'd1440;
    localparam logic [RATE_W:0] DOUBLE_TOL_Q4 = 13'd320;

    // Plausibility window numerators over 256
    localparam logic [PROD_W-1:0] PLAUS_LO_NUM = 21'd166;
    localparam logic [PROD_W-1:0] PLAUS_HI_NUM = 21'd358;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HR_LOW    = 3'd0,
        REG_HR_HIGH   = 3'd1,
        REG_OXY_LOW   = 3'd2,
        REG_OXY_HIGH  = 3'd3,
        REG_OXY_JUMP  = 3'd4,
        REG_MISS_LIM  = 3'd5,
        REG_REJ_LIM   = 3'd6,
        REG_MIN_FILL  = 3'd7
    } cfg_reg_t;

    typedef enum logic [M_USER_W-1:0] {
        V_PUBLISHED   = 3'd0,
        V_BUFFERED    = 3'd1,
        V_NO_BEAT     = 3'd2,
        V_OUT_RANGE   = 3'd3,
        V_JUMP        = 3'd4,
        V_IMPLAUSIBLE = 3'd5,
        V_CLEARED     = 3'd6
    } verdict_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_PLAUS,
        S_MEDIAN,
        S_FINISH
    } hsq_state_t;

    typedef enum logic [1:0] {
        M_IDLE,
        M_LOAD,
        M_SCAN
    } med_state_t;

    // One window slot: corrected rate (Q8.4) and SpO2
    typedef struct packed {
        logic [RATE_W-1:0] rate;
        logic [OXY_W-1:0]  oxy;
    } win_entry_t;

endpackage

`default_nettype wire

// File: src/hsq_window.sv
`default_nettype none

module hsq_window
    import hsq_pkg::*;
#(
    parameter int DEPTH = DEFAULT_WINDOW_DEPTH,
    localparam int IDX_W = $clog2(DEPTH)
)
(
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [IDX_W-1:0] wr_addr,
    input  win_entry_t            wr_data,
    input  wire logic [IDX_W-1:0] rd_addr,
    output win_entry_t            rd_data
);

    // Slots are only read once filled, so no reset.
    win_entry_t slot_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_addr] <= wr_data;
        end
    end

    assign rd_data = slot_reg[rd_addr];

endmodule

`default_nettype wire

// File: src/hsq_median.sv
`default_nettype none

module hsq_median
    import hsq_pkg::*;
#(
    parameter int DEPTH = DEFAULT_WINDOW_DEPTH,
    localparam int IDX_W = $clog2(DEPTH),
    localparam int FILL_W = $clog2(DEPTH + 1)
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [FILL_W-1:0] count,
    output logic [IDX_W-1:0]       rd_addr,
    input  win_entry_t             rd_data,
    output logic                   done,
    output win_entry_t             result
);

    med_state_t        state_reg, state_next;
    logic [FILL_W-1:0] n_reg, n_next;
    logic [IDX_W-1:0]  i_reg, i_next;
    logic [IDX_W-1:0]  j_reg, j_next;
    win_entry_t        cand_reg, cand_next;
    logic [FILL_W-1:0] r_lt_reg, r_lt_next, r_le_reg, r_le_next;
    logic [FILL_W-1:0] o_lt_reg, o_lt_next, o_le_reg, o_le_next;
    logic              r_found_reg, r_found_next, o_found_reg, o_found_next;
    logic              done_reg, done_next;
    win_entry_t        result_reg, result_next;

    logic [FILL_W-1:0] r_lt_tot, r_le_tot, o_lt_tot, o_le_tot;
    logic [FILL_W-1:0] half;
    logic              last_j, r_hit, o_hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg       <= n_next;
        i_reg       <= i_next;
        j_reg       <= j_next;
        cand_reg    <= cand_next;
        r_lt_reg    <= r_lt_next;
        r_le_reg    <= r_le_next;
        o_lt_reg    <= o_lt_next;
        o_le_reg    <= o_le_next;
        r_found_reg <= r_found_next;
        o_found_reg <= o_found_next;
        result_reg  <= result_next;
    end

    // Running rank counts including the entry read this cycle
    assign r_lt_tot = r_lt_reg + FILL_W'(rd_data.rate < cand_reg.rate);
    assign r_le_tot = r_le_reg + FILL_W'(rd_data.rate <= cand_reg.rate);
    assign o_lt_tot = o_lt_reg + FILL_W'(rd_data.oxy < cand_reg.oxy);
    assign o_le_tot = o_le_reg + FILL_W'(rd_data.oxy <= cand_reg.oxy);
    assign half     = n_reg >> 1;
    assign last_j   = (FILL_W'(j_reg) + FILL_W'(1)) == n_reg;
    // Candidate sits at sorted index n/2 (upper median)
    assign r_hit    = (r_lt_tot <= half) && (half < r_le_tot);
    assign o_hit    = (o_lt_tot <= half) && (half < o_le_tot);

    always_comb
    begin
        state_next   = state_reg;
        n_next       = n_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        cand_next    = cand_reg;
        r_lt_next    = r_lt_reg;
        r_le_next    = r_le_reg;
        o_lt_next    = o_lt_reg;
        o_le_next    = o_le_reg;
        r_found_next = r_found_reg;
        o_found_next = o_found_reg;
        result_next  = result_reg;
        done_next    = 1'b0;
        rd_addr      = (state_reg == M_LOAD) ? i_reg : j_reg;

        case (state_reg)
            M_IDLE:
            begin
                if (start)
                begin
                    n_next       = count;
                    i_next       = '0;
                    r_found_next = 1'b0;
                    o_found_next = 1'b0;
                    state_next   = M_LOAD;
                end
            end
            M_LOAD:
            begin
                cand_next  = rd_data;
                j_next     = '0;
                r_lt_next  = '0;
                r_le_next  = '0;
                o_lt_next  = '0;
                o_le_next  = '0;
                state_next = M_SCAN;
            end
            M_SCAN:
            begin
                if (!last_j)
                begin
                    r_lt_next = r_lt_tot;
                    r_le_next = r_le_tot;
                    o_lt_next = o_lt_tot;
                    o_le_next = o_le_tot;
                    j_next    = j_reg + IDX_W'(1);
                end
                else
                begin
                    if (!r_found_reg && r_hit)
                    begin
                        result_next.rate = cand_reg.rate;
                        r_found_next     = 1'b1;
                    end
                    if (!o_found_reg && o_hit)
                    begin
                        result_next.oxy = cand_reg.oxy;
                        o_found_next    = 1'b1;
                    end
                    if ((r_found_reg || r_hit) && (o_found_reg || o_hit))
                    begin
                        done_next  = 1'b1;
                        state_next = M_IDLE;
                    end
                    else
                    begin
                        i_next     = i_reg + IDX_W'(1);
                        state_next = M_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = M_IDLE;
            end
        endcase
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

// File: src/heart_rate_spo2_sample_qualifier.sv
// Channel   Dir  Payload (lowest bit first)                      Accepted when
// s_axis    in   tuser: mode; tdata: beat_ok, rate_q4, oxygen_raw  tvalid && tready
// m_axis    out  tuser: verdict; tdata: shown_rate, shown_oxygen,  tvalid && tready
//                available, display_changed, restart_beats
// cfg       in   cfg_index selects register, cfg_data value        cfg_we
//
// Items are taken one at a time. Clear, no-beat, out-of-range and jump items pass
// the check step and then finish; implausible and buffered items also pass the
// plausibility step. Publishing items add the median ranking in hsq_median, which
// ranks candidates in turn, scanning the whole window fill for each candidate and
// reading one window entry at a time, until both medians are found.
// Reset (rst_n, async low) restores register defaults and clears the control state.
// A waiting result sits in the output register; the next item is accepted
// while it waits, and finishes only once the register is free.
`default_nettype none

module heart_rate_spo2_sample_qualifier
    import hsq_pkg::*;
#(
    parameter int WINDOW_DEPTH = DEFAULT_WINDOW_DEPTH
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // config write port
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    // input items
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [S_DATA_W-1:0]   s_axis_tdata,  // beat_ok, rate_q4[11:0], oxygen_raw[7:0]
    input  wire logic                  s_axis_tuser,  // mode
    // result items
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [M_DATA_W-1:0]        m_axis_tdata,  // shown_rate[7:0], shown_oxygen[6:0],
                                                      // available, display_changed,
                                                      // restart_beats
    output logic [M_USER_W-1:0]        m_axis_tuser   // verdict[2:0]
);

    localparam int IDX_W = $clog2(WINDOW_DEPTH);
    localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
    localparam int CMP_W = (FILL_W > FILL_CFG_W) ? FILL_W : FILL_CFG_W;

    // ---------------- configuration registers ----------------
    logic [7:0]            hr_low_reg, hr_high_reg;
    logic [OXY_W-1:0]      oxy_low_reg, oxy_high_reg, oxy_jump_reg;
    logic [CNT_W-1:0]      miss_lim_reg, rej_lim_reg;
    logic [FILL_CFG_W-1:0] min_fill_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hr_low_reg   <= HR_LOW_RST;
            hr_high_reg  <= HR_HIGH_RST;
            oxy_low_reg  <= OXY_LOW_RST;
            oxy_high_reg <= OXY_HIGH_RST;
            oxy_jump_reg <= OXY_JUMP_RST;
            miss_lim_reg <= MISS_LIMIT_RST;
            rej_lim_reg  <= REJECT_LIMIT_RST;
            min_fill_reg <= MIN_FILL_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_HR_LOW:   hr_low_reg   <= cfg_data;
                REG_HR_HIGH:  hr_high_reg  <= cfg_data;
                REG_OXY_LOW:  oxy_low_reg  <= cfg_data[OXY_W-1:0];
                REG_OXY_HIGH: oxy_high_reg <= cfg_data[OXY_W-1:0];
                REG_OXY_JUMP: oxy_jump_reg <= cfg_data[OXY_W-1:0];
                REG_MISS_LIM: miss_lim_reg <= cfg_data[CNT_W-1:0];
                REG_REJ_LIM:  rej_lim_reg  <= cfg_data[CNT_W-1:0];
                REG_MIN_FILL: min_fill_reg <= cfg_data[FILL_CFG_W-1:0];
                default:      ;
            endcase
        end
    end

    // ---------------- control and qualifier state ----------------
    hsq_state_t         state_reg, state_next;
    logic [IDX_W-1:0]   slot_reg, slot_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic [CNT_W-1:0]   miss_reg, miss_next;
    logic [CNT_W-1:0]   rej_reg, rej_next;
    logic [RATE_W-1:0]  stable_reg, stable_next;      // Q8.4, zero = none
    logic [OXY_IN_W-1:0] last_oxy_reg, last_oxy_next; // zero = none
    logic [SHOWN_RATE_W-1:0] pub_rate_reg, pub_rate_next;
    logic [OXY_W-1:0]   pub_oxy_reg, pub_oxy_next;
    logic               pub_valid_reg, pub_valid_next;
    logic               out_valid_reg, out_valid_next;

    // latched item and per-item results (payload, no reset)
    logic               mode_reg, beat_reg;
    logic [RATE_W-1:0]  rate_reg;
    logic [OXY_IN_W-1:0] oxy_reg;
    logic [RATE_W-1:0]  corr_reg, corr_next;
    logic               res_changed_reg, res_changed_next;
    logic               res_restart_reg, res_restart_next;
    verdict_t           res_verdict_reg, res_verdict_next;
    logic [SHOWN_RATE_W-1:0] out_rate_reg;
    logic [OXY_W-1:0]   out_oxy_reg;
    logic               out_avail_reg, out_changed_reg, out_restart_reg;
    verdict_t           out_verdict_reg;

    logic               in_fire, out_load, withdraw;
    logic               win_we, med_start, med_done;
    win_entry_t         win_wdata, win_rdata, med_result;
    logic [IDX_W-1:0]   win_raddr;

    // step datapath
    logic [CNT_W-1:0]   miss_inc, rej_inc;
    logic               out_of_range, oxy_jumped;
    logic [OXY_IN_W-1:0] oxy_diff;
    logic [RATE_W:0]    dbl, dd, dr;
    logic [RATE_W-1:0]  corr_calc;
    logic [PROD_W-1:0]  corr_scaled, stable_lo, stable_hi;
    logic               plausible;
    logic [FILL_W-1:0]  fill_inc;
    logic [SHOWN_RATE_W-1:0] med_rate_whole;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_load = (state_reg == S_FINISH) && (!out_valid_reg || m_axis_tready);

    assign miss_inc = (miss_reg == '1) ? miss_reg : miss_reg + CNT_W'(1);
    assign rej_inc  = (rej_reg == '1) ? rej_reg : rej_reg + CNT_W'(1);

    assign out_of_range = (rate_reg < {hr_low_reg, 4'b0000})
                       || (rate_reg > {hr_high_reg, 4'b0000})
                       || (oxy_reg < {1'b0, oxy_low_reg})
                       || (oxy_reg > {1'b0, oxy_high_reg});
    assign oxy_diff   = (oxy_reg > last_oxy_reg) ? oxy_reg - last_oxy_reg
                                                 : last_oxy_reg - oxy_reg;
    assign oxy_jumped = (last_oxy_reg != '0) && (oxy_diff > {1'b0, oxy_jump_reg});

    // Halved-rate correction: double when that lands closer to the stable rate
    assign dbl = {rate_reg, 1'b0};
    assign dd  = (dbl > {1'b0, stable_reg}) ? dbl - {1'b0, stable_reg}
                                            : {1'b0, stable_reg} - dbl;
    assign dr  = (rate_reg > stable_reg) ? {1'b0, rate_reg - stable_reg}
                                         : {1'b0, stable_reg - rate_reg};
    assign corr_calc = ((stable_reg != '0) && (rate_reg < DOUBLE_BELOW_Q4)
                        && (dd < dr) && (dd < DOUBLE_TOL_Q4)) ? dbl[RATE_W-1:0] : rate_reg;

    // Plausibility: corr*256 within stable*166 .. stable*358
    assign corr_scaled = PROD_W'({corr_reg, 8'h00});
    assign stable_lo   = PROD_W'(stable_reg) * PLAUS_LO_NUM;
    assign stable_hi   = PROD_W'(stable_reg) * PLAUS_HI_NUM;
    assign plausible   = (stable_reg == '0)
                      || ((corr_scaled >= stable_lo) && (corr_scaled <= stable_hi));

    assign fill_inc = (fill_reg < FILL_W'(WINDOW_DEPTH)) ? fill_reg + FILL_W'(1) : fill_reg;
    assign med_rate_whole = med_result.rate[RATE_W-1:4];

    assign win_wdata.rate = corr_reg;
    assign win_wdata.oxy  = oxy_reg[OXY_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            slot_reg      <= '0;
            fill_reg      <= '0;
            miss_reg      <= '0;
            rej_reg       <= '0;
            stable_reg    <= '0;
            last_oxy_reg  <= '0;
            pub_rate_reg  <= '0;
            pub_oxy_reg   <= '0;
            pub_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            slot_reg      <= slot_next;
            fill_reg      <= fill_next;
            miss_reg      <= miss_next;
            rej_reg       <= rej_next;
            stable_reg    <= stable_next;
            last_oxy_reg  <= last_oxy_next;
            pub_rate_reg  <= pub_rate_next;
            pub_oxy_reg   <= pub_oxy_next;
            pub_valid_reg <= pub_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            mode_reg <= s_axis_tuser;
            beat_reg <= s_axis_tdata[0];
            rate_reg <= s_axis_tdata[12:1];
            oxy_reg  <= s_axis_tdata[20:13];
        end
        corr_reg        <= corr_next;
        res_changed_reg <= res_changed_next;
        res_restart_reg <= res_restart_next;
        res_verdict_reg <= res_verdict_next;
        if (out_load)
        begin
            out_rate_reg    <= pub_rate_reg;
            out_oxy_reg     <= pub_oxy_reg;
            out_avail_reg   <= pub_valid_reg;
            out_changed_reg <= res_changed_reg;
            out_restart_reg <= res_restart_reg;
            out_verdict_reg <= res_verdict_reg;
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        slot_next        = slot_reg;
        fill_next        = fill_reg;
        miss_next        = miss_reg;
        rej_next         = rej_reg;
        stable_next      = stable_reg;
        last_oxy_next    = last_oxy_reg;
        pub_rate_next    = pub_rate_reg;
        pub_oxy_next     = pub_oxy_reg;
        pub_valid_next   = pub_valid_reg;
        corr_next        = corr_reg;
        res_changed_next = res_changed_reg;
        res_restart_next = res_restart_reg;
        res_verdict_next = res_verdict_reg;
        withdraw         = 1'b0;
        win_we           = 1'b0;
        med_start        = 1'b0;

        // output register drains independently of the sequencer
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                res_changed_next = 1'b0;
                res_restart_next = 1'b0;
                state_next       = S_FINISH;
                if (mode_reg)
                begin
                    // clear after motion or stale data
                    res_changed_next = (pub_rate_reg != '0) || (pub_oxy_reg != '0)
                                    || pub_valid_reg;
                    withdraw         = 1'b1;
                    fill_next        = '0;
                    slot_next        = '0;
                    res_restart_next = 1'b1;
                    res_verdict_next = V_CLEARED;
                end
                else if (!beat_reg)
                begin
                    res_verdict_next = V_NO_BEAT;
                    if (pub_valid_reg)
                    begin
                        miss_next = miss_inc;
                        if (miss_inc >= miss_lim_reg)
                        begin
                            withdraw         = 1'b1;
                            res_changed_next = 1'b1;
                        end
                    end
                end
                else if (out_of_range)
                begin
                    res_verdict_next = V_OUT_RANGE;
                    miss_next        = miss_inc;
                    if ((miss_inc >= miss_lim_reg) && pub_valid_reg)
                    begin
                        withdraw         = 1'b1;
                        res_changed_next = 1'b1;
                        res_restart_next = 1'b1;
                    end
                end
                else if (oxy_jumped)
                begin
                    last_oxy_next    = oxy_reg;
                    res_verdict_next = V_JUMP;
                end
                else
                begin
                    last_oxy_next = oxy_reg;
                    corr_next     = corr_calc;
                    state_next    = S_PLAUS;
                end
            end
            S_PLAUS:
            begin
                state_next = S_FINISH;
                if (!plausible)
                begin
                    res_verdict_next = V_IMPLAUSIBLE;
                    rej_next         = rej_inc;
                    if (rej_inc >= rej_lim_reg)
                    begin
                        // re-anchor on the rejected rate
                        stable_next = corr_reg;
                        rej_next    = '0;
                        fill_next   = '0;
                        slot_next   = '0;
                    end
                end
                else
                begin
                    rej_next  = '0;
                    miss_next = '0;
                    win_we    = 1'b1;
                    slot_next = (slot_reg == IDX_W'(WINDOW_DEPTH - 1)) ? '0
                                                                       : slot_reg + IDX_W'(1);
                    fill_next = fill_inc;
                    if (CMP_W'(fill_inc) < CMP_W'(min_fill_reg))
                    begin
                        res_verdict_next = V_BUFFERED;
                    end
                    else
                    begin
                        med_start  = 1'b1;
                        state_next = S_MEDIAN;
                    end
                end
            end
            S_MEDIAN:
            begin
                if (med_done)
                begin
                    if (fill_reg == FILL_W'(WINDOW_DEPTH))
                    begin
                        stable_next = {med_rate_whole, 4'b0000};
                    end
                    res_changed_next = (med_rate_whole != pub_rate_reg)
                                    || (med_result.oxy != pub_oxy_reg);
                    pub_rate_next    = med_rate_whole;
                    pub_oxy_next     = med_result.oxy;
                    pub_valid_next   = 1'b1;
                    res_verdict_next = V_PUBLISHED;
                    state_next       = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (withdraw)
        begin
            pub_rate_next  = '0;
            pub_oxy_next   = '0;
            pub_valid_next = 1'b0;
            miss_next      = '0;
            stable_next    = '0;
            rej_next       = '0;
            last_oxy_next  = '0;
        end
    end

    // ---------------- window storage and median ranking ----------------
    hsq_window #(
        .DEPTH   (WINDOW_DEPTH)
    ) u_window (
        .clk     (clk),
        .wr_en   (win_we),
        .wr_addr (slot_reg),
        .wr_data (win_wdata),
        .rd_addr (win_raddr),
        .rd_data (win_rdata)
    );

    hsq_median #(
        .DEPTH   (WINDOW_DEPTH)
    ) u_median (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (med_start),
        .count   (fill_inc),
        .rd_addr (win_raddr),
        .rd_data (win_rdata),
        .done    (med_done),
        .result  (med_result)
    );

    // ---------------- ports ----------------
    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b000000, out_restart_reg, out_changed_reg, out_avail_reg,
                            out_oxy_reg, out_rate_reg};
    assign m_axis_tuser  = out_verdict_reg;

endmodule

`default_nettype wire

// File: src/hsq_checker.sv
`default_nettype none

`include "heart_rate_spo2_sample_qualifier_macros.svh"

module hsq_checker
    import hsq_pkg::*;
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                s_axis_tvalid,
    input wire logic                s_axis_tready,
    input wire logic                m_axis_tvalid,
    input wire logic                m_axis_tready,
    input wire logic [M_DATA_W-1:0] m_axis_tdata,
    input wire logic [M_USER_W-1:0] m_axis_tuser
);

    // stalled result holds
    `HSQ_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // one item in flight: busy right after an accept
    `HSQ_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // withdrawn state shows zeros
    `HSQ_ASSERT_SAME(a_zero_when_unavail, clk, rst_n, m_axis_tvalid && !m_axis_tdata[15], m_axis_tdata[14:0] == 15'd0)

    // clear always restarts the beat validator and withdraws
    `HSQ_ASSERT_SAME(a_clear_restarts, clk, rst_n, m_axis_tvalid && (m_axis_tuser == V_CLEARED), m_axis_tdata[17] && !m_axis_tdata[15])

    // a publish verdict leaves values available
    `HSQ_ASSERT_SAME(a_publish_avail, clk, rst_n, m_axis_tvalid && (m_axis_tuser == V_PUBLISHED), m_axis_tdata[15])

endmodule

bind heart_rate_spo2_sample_qualifier hsq_checker u_hsq_checker (.*);

`default_nettype wire
